/* src/scene_text_tokenizer_top_macros.svh */
// Assertion macros shared by the tokenizer modules.
`ifndef SCENE_TEXT_TOKENIZER_TOP_MACROS_SVH
`define SCENE_TEXT_TOKENIZER_TOP_MACROS_SVH

// Checked outside reset.
`define STT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/stt_pkg.sv */
package stt_pkg;

   // default sizes
   localparam int STT_LENGTH_BITS   = 16;
   localparam int STT_POSITION_BITS = 32;
   localparam int STT_QUEUE_DEPTH   = 2;
   localparam int STT_MAX_RESULTS   = 4;

   // token kinds
   localparam logic [2:0] KIND_CHAR   = 3'd0;
   localparam logic [2:0] KIND_IDENT  = 3'd1;
   localparam logic [2:0] KIND_INT    = 3'd2;
   localparam logic [2:0] KIND_FLOAT  = 3'd3;
   localparam logic [2:0] KIND_STRING = 3'd4;
   localparam logic [2:0] KIND_EOF    = 3'd5;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_EOF_COMMENT = 2'd1;
   localparam logic [1:0] ERR_EOF_STRING  = 2'd2;
   localparam logic [1:0] ERR_NL_STRING   = 2'd3;

   // characters
   localparam logic [6:0] CH_NL     = 7'h0A;
   localparam logic [6:0] CH_QUOTE  = 7'h22;
   localparam logic [6:0] CH_STAR   = 7'h2A;
   localparam logic [6:0] CH_PLUS   = 7'h2B;
   localparam logic [6:0] CH_MINUS  = 7'h2D;
   localparam logic [6:0] CH_DOT    = 7'h2E;
   localparam logic [6:0] CH_SLASH  = 7'h2F;
   localparam logic [6:0] CH_ZERO   = 7'h30;
   localparam logic [6:0] CH_NINE   = 7'h39;
   localparam logic [6:0] CH_UPPER_E = 7'h45;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_UNDER  = 7'h5F;
   localparam logic [6:0] CH_LOWER_E = 7'h65;

   // one token as delivered
   typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  char_value;
      logic [31:0] int_value;
      logic [31:0] start;
      logic [15:0] length;
      logic [31:0] line;
      logic [1:0]  err;
   } result_type;

   // all tokens caused by one input word
   typedef struct packed {
      logic [2:0]                         cnt;
      result_type [STT_MAX_RESULTS-1:0]   res;
   } entry_type;

   function automatic logic is_digit(logic [6:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(logic [6:0] c);
      return ((c >= 7'h61) && (c <= 7'h7A)) || ((c >= 7'h41) && (c <= 7'h5A));
   endfunction

   // first character of an identifier
   function automatic logic is_ident_first(logic [6:0] c);
      return is_alpha(c) || (c == CH_UNDER);
   endfunction

   // follow character of an identifier
   function automatic logic is_ident(logic [6:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_blank(logic [6:0] c);
      return (c == 7'h09) || (c == 7'h0B) || (c == 7'h0C) || (c == 7'h0D) || (c == 7'h20);
   endfunction

   function automatic logic is_exp(logic [6:0] c);
      return (c == CH_LOWER_E) || (c == CH_UPPER_E);
   endfunction

   function automatic logic is_sign(logic [6:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

endpackage

/* src/stt_front.sv */
module stt_front #(
   parameter int LENGTH_BITS   = stt_pkg::STT_LENGTH_BITS,
   parameter int POSITION_BITS = stt_pkg::STT_POSITION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   output logic                ready_o,
   input  logic [6:0]          char_i,
   input  logic                eof_i,
   output logic                push_o,
   output stt_pkg::entry_type  entry_o,
   input  logic                full_i
);
   import stt_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
   localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);

   typedef enum logic [12:0] {
      M_IDLE     = 13'b0000000000001,
      M_IDENT    = 13'b0000000000010,
      M_INT      = 13'b0000000000100,
      M_SIGN     = 13'b0000000001000,
      M_SIGN_DOT = 13'b0000000010000,
      M_DOT      = 13'b0000000100000,
      M_FRAC     = 13'b0000001000000,
      M_EXP_E    = 13'b0000010000000,
      M_EXP_SIGN = 13'b0000100000000,
      M_EXP_DIG  = 13'b0001000000000,
      M_SLASH    = 13'b0010000000000,
      M_COMMENT  = 13'b0100000000000,
      M_STRING   = 13'b1000000000000
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic [31:0]              acc;
      logic                     neg;
      logic [POSITION_BITS-1:0] tstart;
      logic [LENGTH_BITS-1:0]   len;
      logic [31:0]              line;
      logic [6:0]               prev;
      logic [6:0]               la0;
      logic [6:0]               la1;
      logic [POSITION_BITS-1:0] held;
   } scan_type;

   // scanner state after reset
   localparam scan_type SCAN_RESET = '{mode: M_IDLE, acc: 32'd0, neg: 1'b0, tstart: '0,
                                       len: '0, line: 32'd1, prev: 7'd0, la0: 7'd0,
                                       la1: 7'd0, held: '0};

   // one pass of the scanner over a single character
   typedef struct packed {
      scan_type         st;
      result_type [1:0] res;
      logic [1:0]       n;
   } part_type;

   typedef struct packed {
      scan_type                         st;
      result_type [STT_MAX_RESULTS-1:0] res;
      logic [2:0]                       n;
   } step_type;

   function automatic logic [POSITION_BITS-1:0] pos_inc(logic [POSITION_BITS-1:0] p);
      return (p == POS_MAX) ? p : p + POSITION_BITS'(1);
   endfunction

   function automatic logic [LENGTH_BITS-1:0] len_add(logic [LENGTH_BITS-1:0] l,
                                                      logic [1:0] k);
      logic [LENGTH_BITS+1:0] sum;
      sum = {2'b00, l} + (LENGTH_BITS+2)'(k);
      return (sum > (LENGTH_BITS+2)'(LEN_MAX)) ? LEN_MAX : sum[LENGTH_BITS-1:0];
   endfunction

   function automatic logic [31:0] line_inc(logic [31:0] l);
      return (l == 32'hFFFF_FFFF) ? l : l + 32'd1;
   endfunction

   function automatic result_type make(logic [2:0] kind, logic [6:0] cv, logic [31:0] iv,
                                       logic [POSITION_BITS-1:0] start,
                                       logic [LENGTH_BITS-1:0] len,
                                       logic [31:0] line, logic [1:0] err);
      result_type r;
      r.kind       = kind;
      r.char_value = cv;
      r.int_value  = iv;
      r.start      = 32'(start);
      r.length     = 16'(len);
      r.line       = line;
      r.err        = err;
      return r;
   endfunction

   // scan one character in any mode without held lookahead
   function automatic part_type feed(scan_type s, logic [6:0] c, logic eof,
                                     logic [POSITION_BITS-1:0] pos);
      part_type p;
      logic     to_idle;
      logic [6:0] d;
      p.st    = s;
      p.res   = '0;
      p.n     = '0;
      to_idle = 1'b0;
      d       = c - CH_ZERO;
      case (s.mode)
         M_IDENT: begin
            if (!eof && is_ident(c)) begin
               p.st.len = len_add(s.len, 2'd1);
            end else begin
               p.res[0] = make(KIND_IDENT, '0, '0, s.tstart, s.len, s.line, ERR_NONE);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end
         end
         M_INT: begin
            if (!eof && is_digit(c)) begin
               p.st.acc = (s.acc << 3) + (s.acc << 1) + 32'(d);
               p.st.len = len_add(s.len, 2'd1);
            end else if (!eof && (c == CH_DOT)) begin
               p.st.len  = len_add(s.len, 2'd1);
               p.st.mode = M_FRAC;
            end else if (!eof && is_exp(c)) begin
               p.st.la0  = c;
               p.st.held = pos;
               p.st.mode = M_EXP_E;
            end else begin
               p.res[0] = make(KIND_INT, '0, s.neg ? (32'd0 - s.acc) : s.acc,
                               s.tstart, s.len, s.line, ERR_NONE);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end
         end
         M_SIGN: begin
            if (!eof && is_digit(c)) begin
               p.st.acc  = 32'(d);
               p.st.len  = len_add(s.len, 2'd1);
               p.st.mode = M_INT;
            end else if (!eof && (c == CH_DOT)) begin
               p.st.held = pos;
               p.st.mode = M_SIGN_DOT;
            end else begin
               p.res[0] = make(KIND_CHAR, s.prev, '0, s.tstart, LEN_ONE, s.line, ERR_NONE);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end
         end
         M_DOT: begin
            if (!eof && is_digit(c)) begin
               p.st.len  = len_add(s.len, 2'd1);
               p.st.mode = M_FRAC;
            end else begin
               p.res[0] = make(KIND_CHAR, CH_DOT, '0, s.tstart, LEN_ONE, s.line, ERR_NONE);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end
         end
         M_FRAC: begin
            if (!eof && is_digit(c)) begin
               p.st.len = len_add(s.len, 2'd1);
            end else if (!eof && is_exp(c)) begin
               p.st.la0  = c;
               p.st.held = pos;
               p.st.mode = M_EXP_E;
            end else begin
               p.res[0] = make(KIND_FLOAT, '0, '0, s.tstart, s.len, s.line, ERR_NONE);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end
         end
         M_EXP_DIG: begin
            if (!eof && is_digit(c)) begin
               p.st.len = len_add(s.len, 2'd1);
            end else begin
               p.res[0] = make(KIND_FLOAT, '0, '0, s.tstart, s.len, s.line, ERR_NONE);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end
         end
         M_SLASH: begin
            if (!eof && (c == CH_STAR)) begin
               p.st.prev = '0;
               p.st.mode = M_COMMENT;
            end else begin
               p.res[0] = make(KIND_CHAR, CH_SLASH, '0, s.tstart, LEN_ONE, s.line, ERR_NONE);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end
         end
         M_COMMENT: begin
            if (eof) begin
               p.res[0]  = make(KIND_EOF, '0, '0, pos, '0, s.line, ERR_EOF_COMMENT);
               p.n       = 2'd1;
               p.st.mode = M_IDLE;
            end else begin
               if (c == CH_NL) begin
                  p.st.line = line_inc(s.line);
               end else if ((c == CH_SLASH) && (s.prev == CH_STAR)) begin
                  p.st.mode = M_IDLE;
               end
               p.st.prev = c;
            end
         end
         M_STRING: begin
            if (eof) begin
               p.res[0] = make(KIND_CHAR, CH_NL, '0, s.tstart, s.len, s.line, ERR_EOF_STRING);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end else if ((c == CH_QUOTE) && (s.prev != CH_BSLASH)) begin
               p.res[0]  = make(KIND_STRING, '0, '0, s.tstart, s.len, s.line, ERR_NONE);
               p.n       = 2'd1;
               p.st.mode = M_IDLE;
               p.st.prev = c;
            end else if (c == CH_NL) begin
               p.res[0] = make(KIND_CHAR, CH_NL, '0, s.tstart, s.len, s.line, ERR_NL_STRING);
               p.n      = 2'd1;
               to_idle  = 1'b1;
            end else begin
               p.st.len  = len_add(s.len, 2'd1);
               p.st.prev = c;
            end
         end
         default: begin
            to_idle = 1'b1;
         end
      endcase

      // back to idle: end of file, newline, blank or start of a new token
      if (to_idle) begin
         p.st.mode = M_IDLE;
         if (eof) begin
            p.res[p.n[0]] = make(KIND_EOF, '0, '0, pos, '0, p.st.line, ERR_NONE);
            p.n           = p.n + 2'd1;
         end else if (c == CH_NL) begin
            p.st.line = line_inc(p.st.line);
         end else if (!is_blank(c)) begin
            p.st.tstart = pos;
            p.st.len    = LEN_ONE;
            if (is_ident_first(c)) begin
               p.st.mode = M_IDENT;
            end else if (is_digit(c)) begin
               p.st.acc  = 32'(d);
               p.st.neg  = 1'b0;
               p.st.mode = M_INT;
            end else if (is_sign(c)) begin
               p.st.neg  = (c == CH_MINUS);
               p.st.prev = c;
               p.st.mode = M_SIGN;
            end else if (c == CH_DOT) begin
               p.st.mode = M_DOT;
            end else if (c == CH_SLASH) begin
               p.st.mode = M_SLASH;
            end else if (c == CH_QUOTE) begin
               p.st.tstart = pos_inc(pos);
               p.st.len    = '0;
               p.st.prev   = c;
               p.st.mode   = M_STRING;
            end else begin
               p.res[p.n[0]] = make(KIND_CHAR, c, '0, pos, LEN_ONE, p.st.line, ERR_NONE);
               p.n           = p.n + 2'd1;
            end
         end
      end
      return p;
   endfunction

   // append one pass to the step
   function automatic step_type append_part(step_type s, part_type p);
      step_type r;
      r    = s;
      r.st = p.st;
      for (int k = 0; k < 2; k++) begin
         if ((2'(k) < p.n) && (r.n < 3'(STT_MAX_RESULTS))) begin
            r.res[r.n[1:0]] = p.res[k];
            r.n             = r.n + 3'd1;
         end
      end
      return r;
   endfunction

   // full step: re-scans held lookahead where a float or sign falls apart
   function automatic step_type scan(scan_type s, logic [6:0] c, logic eof,
                                     logic [POSITION_BITS-1:0] pos);
      step_type r;
      scan_type t;
      r.st  = s;
      r.res = '0;
      r.n   = '0;
      t     = s;
      t.mode = M_IDLE;
      case (s.mode)
         M_SIGN_DOT: begin
            if (!eof && is_digit(c)) begin
               r.st.len  = len_add(s.len, 2'd2);
               r.st.mode = M_FRAC;
            end else begin
               r.res[0] = make(KIND_CHAR, s.prev, '0, s.tstart, LEN_ONE, s.line, ERR_NONE);
               r.n      = 3'd1;
               r = append_part(r, feed(t, CH_DOT, 1'b0, s.held));
               r = append_part(r, feed(r.st, c, eof, pos));
            end
         end
         M_EXP_E: begin
            if (!eof && is_digit(c)) begin
               r.st.len  = len_add(s.len, 2'd2);
               r.st.mode = M_EXP_DIG;
            end else if (!eof && is_sign(c)) begin
               r.st.la1  = c;
               r.st.mode = M_EXP_SIGN;
            end else begin
               r.res[0] = make(KIND_FLOAT, '0, '0, s.tstart, s.len, s.line, ERR_NONE);
               r.n      = 3'd1;
               r = append_part(r, feed(t, s.la0, 1'b0, s.held));
               r = append_part(r, feed(r.st, c, eof, pos));
            end
         end
         M_EXP_SIGN: begin
            if (!eof && is_digit(c)) begin
               r.st.len  = len_add(s.len, 2'd3);
               r.st.mode = M_EXP_DIG;
            end else begin
               r.res[0] = make(KIND_FLOAT, '0, '0, s.tstart, s.len, s.line, ERR_NONE);
               r.n      = 3'd1;
               r = append_part(r, feed(t, s.la0, 1'b0, s.held));
               r = append_part(r, feed(r.st, s.la1, 1'b0, pos_inc(s.held)));
               r = append_part(r, feed(r.st, c, eof, pos));
            end
         end
         default: begin
            r = append_part(r, feed(s, c, eof, pos));
         end
      endcase
      return r;
   endfunction

   scan_type                 st_ff, st_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   step_type                 step;
   logic                     accept;

   assign ready_o = !full_i;
   assign accept  = valid_i && !full_i;
   assign step    = scan(st_ff, char_i, eof_i, pos_ff);

   // queue write
   assign push_o      = accept && (step.n != 3'd0);
   assign entry_o.cnt = step.n;
   assign entry_o.res = step.res;

   // next scanner state
   always_comb begin
      st_in  = st_ff;
      pos_in = pos_ff;
      if (accept) begin
         st_in = step.st;
         if (!eof_i) begin
            pos_in = pos_inc(pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= SCAN_RESET;
         pos_ff <= '0;
      end else begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
      end
   end

endmodule

/* src/stt_fifo.sv */
`include "scene_text_tokenizer_top_macros.svh"

module stt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_i,
   input  stt_pkg::entry_type  entry_i,
   output logic                full_o,
   input  logic                pop_i,
   output logic                valid_o,
   output stt_pkg::entry_type  head_o
);
   import stt_pkg::*;

   localparam int DEPTH = STT_QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] LEVEL_FULL = CW'(DEPTH);

   entry_type      mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  level_ff, level_in;

   assign full_o  = (level_ff == LEVEL_FULL);
   assign valid_o = (level_ff != '0);
   assign head_o  = mem_ff[rd_ff];

   // pointers and fill level
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      level_in = level_ff;
      if (push_i) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PW'(1);
      end
      if (pop_i) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PW'(1);
      end
      if (push_i && !pop_i) begin
         level_in = level_ff + CW'(1);
      end else if (!push_i && pop_i) begin
         level_in = level_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ff] <= entry_i;
      end
   end

   `STT_ASSERT(a_no_overflow, !(push_i && full_o), "push into full queue")
   `STT_ASSERT(a_no_underflow, !(pop_i && !valid_o), "pop from empty queue")
   `STT_ASSERT(a_level_bound, level_ff <= LEVEL_FULL, "queue level out of range")
   `STT_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> (level_ff == '0), "queue not empty after reset")

endmodule

/* src/stt_back.sv */
`include "scene_text_tokenizer_top_macros.svh"

module stt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   input  stt_pkg::entry_type   head_i,
   output logic                 pop_o,
   output logic                 out_valid_o,
   input  logic                 out_ready_i,
   output stt_pkg::result_type  out_res_o,
   output logic                 out_last_o
);
   import stt_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign out_valid_o = valid_i;
   assign out_res_o   = head_i.res[idx_ff];
   assign out_last_o  = ({1'b0, idx_ff} == (head_i.cnt - 3'd1));
   assign take        = valid_i && out_ready_i;
   assign pop_o       = take && out_last_o;

   // walk through the tokens of the head word
   always_comb begin
      idx_in = idx_ff;
      if (pop_o) begin
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `STT_ASSERT(a_head_nonempty, valid_i |-> (head_i.cnt != 3'd0), "empty word in queue")
   `STT_ASSERT(a_idx_in_range, valid_i |-> ({1'b0, idx_ff} < head_i.cnt), "token index past count")
   `STT_ASSERT(a_run_continues, (take && !out_last_o) |=> out_valid_o, "run broken off")

endmodule

/* src/scene_text_tokenizer_top.sv */
// A character's tokens enter the token queue when the character is accepted and are shown
// from the queue head; further tokens of the same character follow one per cycle while rsp_tready is high.
// Input: one character per cycle while the two-word token queue has room;
// tokens leave one per cycle while rsp_tready is high, so output bursts of up to four slow the input.
// Reset: synchronous, clears scanner state (line counter to one) and empties the queue.
module scene_text_tokenizer_top #(
   parameter int LENGTH_BITS   = stt_pkg::STT_LENGTH_BITS,
   parameter int POSITION_BITS = stt_pkg::STT_POSITION_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_code[6:0], zero pad[7]
   input  logic         req_tuser,   // end_of_input[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // char_value[6:0], int_value[38:7],
                                     // start_position[70:39], token_length[86:71],
                                     // line_number[118:87], zero pad[119]
   output logic [4:0]   rsp_tuser,   // token_kind[2:0], error_code[4:3]
   output logic         rsp_tlast
);
   import stt_pkg::*;

   logic       push, full, pop, head_valid;
   entry_type  entry, head;
   result_type res;

   stt_front #(
      .LENGTH_BITS   (LENGTH_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .valid_i (req_tvalid),
      .ready_o (req_tready),
      .char_i  (req_tdata[6:0]),
      .eof_i   (req_tuser),
      .push_o  (push),
      .entry_o (entry),
      .full_i  (full)
   );

   stt_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .entry_i (entry),
      .full_o  (full),
      .pop_i   (pop),
      .valid_o (head_valid),
      .head_o  (head)
   );

   stt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .valid_i     (head_valid),
      .head_i      (head),
      .pop_o       (pop),
      .out_valid_o (rsp_tvalid),
      .out_ready_i (rsp_tready),
      .out_res_o   (res),
      .out_last_o  (rsp_tlast)
   );

   // pack result word
   assign rsp_tdata = {1'b0, res.line, res.length, res.start, res.int_value, res.char_value};
   assign rsp_tuser = {res.err, res.kind};

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_IDENT, S_INT, S_SIGN, S_SIGN_DOT, S_DOT, S_FRAC,
      S_EXP_E, S_EXP_SIGN, S_EXP_DIG, S_SLASH, S_COMMENT, S_STRING
   } scan_state_t;

   typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  cval;
      logic [31:0] ival;
      logic [31:0] start;
      logic [15:0] len;
      logic [31:0] line;
      logic [1:0]  err;
      logic        last;
   } token_t;

   localparam int LIMIT_CYCLES = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;  // char_code[6:0], zero pad[7]
   logic         req_tuser = 1'b0; // end_of_input[0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;   // char_value[6:0], int_value[38:7], start[70:39],
                              // length[86:71], line[118:87], zero pad[119]
   logic [4:0]   rsp_tuser;   // token_kind[2:0], error_code[4:3]
   logic         rsp_tlast;

   scene_text_tokenizer_top dut (.*);

   always #4 clock = ~clock;

   // scanner shadow state
   scan_state_t mode;
   logic [31:0] acc, tok_start, pos_cnt, line_cnt, held_pos;
   logic        neg;
   logic [15:0] len_cnt;
   logic [6:0]  prev_ch, held_e, held_sign;

   token_t expected_tokens[$];
   int     step_count;
   int     errors = 0;
   logic   quiet_out = 1'b0;
   logic   no_idle = 1'b0;

   function automatic bit dig(logic [6:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction
   function automatic bit alpha(logic [6:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic bit blank(logic [6:0] c);
      return c == 9 || c == 11 || c == 12 || c == 13 || c == 32;
   endfunction
   function automatic bit expo(logic [6:0] c);
      return c == CH_LOWER_E || c == CH_UPPER_E;
   endfunction
   function automatic logic [31:0] sat_inc(logic [31:0] p);
      return (p == 32'hFFFF_FFFF) ? p : p + 1;
   endfunction
   function automatic void grow(int n);
      int v;
      v = len_cnt + n;
      len_cnt = (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic void push_token(logic [2:0] k, logic [6:0] cv, logic [31:0] iv,
                                      logic [31:0] st, logic [15:0] ln, logic [1:0] er);
      token_t t;
      if (step_count >= STT_MAX_RESULTS) return;
      t = '{k, cv, iv, st, ln, line_cnt, er, 1'b0};
      expected_tokens.push_back(t);
      step_count++;
   endfunction

   // one character through the scanner; recursion handles re-scanned lookahead
   function automatic void scan_char(logic [6:0] c, bit eof, logic [31:0] pos);
      case (mode)
         S_IDENT: begin
            if (!eof && (alpha(c) || dig(c) || c == CH_UNDER)) begin grow(1); return; end
            push_token(KIND_IDENT, 0, 0, tok_start, len_cnt, ERR_NONE);
         end
         S_INT: begin
            if (!eof) begin
               if (dig(c)) begin acc = acc * 10 + (c - CH_ZERO); grow(1); return; end
               if (c == CH_DOT) begin grow(1); mode = S_FRAC; return; end
               if (expo(c)) begin held_e = c; held_pos = pos; mode = S_EXP_E; return; end
            end
            push_token(KIND_INT, 0, neg ? -acc : acc, tok_start, len_cnt, ERR_NONE);
         end
         S_SIGN: begin
            if (!eof) begin
               if (dig(c)) begin acc = c - CH_ZERO; grow(1); mode = S_INT; return; end
               if (c == CH_DOT) begin held_pos = pos; mode = S_SIGN_DOT; return; end
            end
            push_token(KIND_CHAR, prev_ch, 0, tok_start, 1, ERR_NONE);
         end
         S_SIGN_DOT: begin
            if (!eof && dig(c)) begin grow(2); mode = S_FRAC; return; end
            push_token(KIND_CHAR, prev_ch, 0, tok_start, 1, ERR_NONE);
            mode = S_IDLE;
            scan_char(CH_DOT, 0, held_pos);
            scan_char(c, eof, pos);
            return;
         end
         S_DOT: begin
            if (!eof && dig(c)) begin grow(1); mode = S_FRAC; return; end
            push_token(KIND_CHAR, CH_DOT, 0, tok_start, 1, ERR_NONE);
         end
         S_FRAC: begin
            if (!eof) begin
               if (dig(c)) begin grow(1); return; end
               if (expo(c)) begin held_e = c; held_pos = pos; mode = S_EXP_E; return; end
            end
            push_token(KIND_FLOAT, 0, 0, tok_start, len_cnt, ERR_NONE);
         end
         S_EXP_E: begin
            if (!eof) begin
               if (dig(c)) begin grow(2); mode = S_EXP_DIG; return; end
               if (c == CH_PLUS || c == CH_MINUS) begin
                  held_sign = c; mode = S_EXP_SIGN; return;
               end
            end
            push_token(KIND_FLOAT, 0, 0, tok_start, len_cnt, ERR_NONE);
            mode = S_IDLE;
            scan_char(held_e, 0, held_pos);
            scan_char(c, eof, pos);
            return;
         end
         S_EXP_SIGN: begin
            if (!eof && dig(c)) begin grow(3); mode = S_EXP_DIG; return; end
            push_token(KIND_FLOAT, 0, 0, tok_start, len_cnt, ERR_NONE);
            mode = S_IDLE;
            scan_char(held_e, 0, held_pos);
            scan_char(held_sign, 0, sat_inc(held_pos));
            scan_char(c, eof, pos);
            return;
         end
         S_EXP_DIG: begin
            if (!eof && dig(c)) begin grow(1); return; end
            push_token(KIND_FLOAT, 0, 0, tok_start, len_cnt, ERR_NONE);
         end
         S_SLASH: begin
            if (!eof && c == CH_STAR) begin prev_ch = 0; mode = S_COMMENT; return; end
            push_token(KIND_CHAR, CH_SLASH, 0, tok_start, 1, ERR_NONE);
         end
         S_COMMENT: begin
            if (eof) begin
               push_token(KIND_EOF, 0, 0, pos, 0, ERR_EOF_COMMENT);
               mode = S_IDLE;
               return;
            end
            if (c == CH_NL) line_cnt = sat_inc(line_cnt);
            else if (c == CH_SLASH && prev_ch == CH_STAR) mode = S_IDLE;
            prev_ch = c;
            return;
         end
         S_STRING: begin
            if (eof) begin
               push_token(KIND_CHAR, CH_NL, 0, tok_start, len_cnt, ERR_EOF_STRING);
            end else if (c == CH_QUOTE && prev_ch != CH_BSLASH) begin
               push_token(KIND_STRING, 0, 0, tok_start, len_cnt, ERR_NONE);
               mode = S_IDLE;
               prev_ch = c;
               return;
            end else if (c == CH_NL) begin
               push_token(KIND_CHAR, CH_NL, 0, tok_start, len_cnt, ERR_NL_STRING);
            end else begin
               grow(1);
               prev_ch = c;
               return;
            end
         end
         default: ;
      endcase

      // idle: end of file, newline, blank or start of a new token
      mode = S_IDLE;
      if (eof) begin push_token(KIND_EOF, 0, 0, pos, 0, ERR_NONE); return; end
      if (blank(c)) return;
      if (c == CH_NL) begin line_cnt = sat_inc(line_cnt); return; end
      tok_start = pos;
      len_cnt = 1;
      if (alpha(c) || c == CH_UNDER) mode = S_IDENT;
      else if (dig(c)) begin acc = c - CH_ZERO; neg = 0; mode = S_INT; end
      else if (c == CH_PLUS || c == CH_MINUS) begin
         neg = (c == CH_MINUS); prev_ch = c; mode = S_SIGN;
      end
      else if (c == CH_DOT) mode = S_DOT;
      else if (c == CH_SLASH) mode = S_SLASH;
      else if (c == CH_QUOTE) begin
         tok_start = sat_inc(pos); len_cnt = 0; prev_ch = c; mode = S_STRING;
      end
      else push_token(KIND_CHAR, c, 0, pos, 1, ERR_NONE);
   endfunction

   function automatic void predict_word(logic [6:0] c, bit eof);
      logic [31:0] p;
      p = pos_cnt;
      step_count = 0;
      scan_char(c, eof, p);
      if (!eof) pos_cnt = sat_inc(p);
      if (step_count > 0) expected_tokens[$].last = 1'b1;
   endfunction

   // sender; valid stays up after a word unless an idle gap follows
   task automatic send_word(logic [6:0] c, bit eof);
      while (!no_idle && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, c};
      req_tuser  <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(c, eof);
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_word(s[i][6:0], 0);
   endtask

   // receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset || quiet_out) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 22);
   end

   // checker
   always @(posedge clock) begin
      token_t got, exp_t;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[2:0], rsp_tdata[6:0], rsp_tdata[38:7], rsp_tdata[70:39],
                 rsp_tdata[86:71], rsp_tdata[118:87], rsp_tuser[4:3], rsp_tlast};
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token %h", $time, got);
            errors++;
         end else begin
            exp_t = expected_tokens.pop_front();
            if (got !== exp_t) begin
               $display("%0t: token mismatch expected %h actual %h", $time, exp_t, got);
               errors++;
            end
         end
      end
   end

   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // random source text; mostly well-formed lexemes
   string frags[] = '{"abc", "_x9", "123", "-45", "+7", "3.14", "2e5", "1.5E-3", "7e",
                      "8e+", "+.", "-.5", ".", ".9", "/", "/* c */", "/*a\n*/",
                      "\"hi\"", "\"a\\\"b\"", " ", "\n", "\t", "(", ";", "9e+x",
                      "4294967296", "**", "/*/*/"};

   // directed rows; the first row carries a typed expectation
   typedef struct {
      string text;
      bit    eof;
   } row_t;
   row_t rows[] = '{
      '{"", 1},
      '{"x", 0}, '{"\x7f\x00 ", 0}, '{"12e ", 0}, '{"12e+;", 0}, '{"+.", 0}, '{"-.x", 0},
      '{"1.5e3 ", 0}, '{"/*/", 0}, '{"*/ ", 0}, '{"\"a\\\"b\" ", 0},
      '{"99999999999 ", 0}, '{"\"ab\n", 0}, '{"/* open", 1}, '{"\"open", 1},
      '{"-12 foo_1 .5", 0}, '{"+3", 1}
   };

   initial begin
      logic [6:0] c;
      mode = S_IDLE; acc = 0; neg = 0; tok_start = 0; pos_cnt = 0; len_cnt = 0;
      line_cnt = 1; prev_ch = 0; held_e = 0; held_sign = 0; held_pos = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; the first row is plain end of file at reset
      foreach (rows[r]) begin
         send_text(rows[r].text);
         if (rows[r].eof) send_word(7'h7F, 1);
         if (r == 0 && !(expected_tokens.size() == 1 && expected_tokens[0] ==
             token_t'{KIND_EOF, 7'd0, 32'd0, 32'd0, 16'd0, 32'd1, ERR_NONE, 1'b1})) begin
            $display("%0t: reset end-of-file expected %h actual %h", $time,
                     token_t'{KIND_EOF, 7'd0, 32'd0, 32'd0, 16'd0, 32'd1, ERR_NONE, 1'b1},
                     expected_tokens[0]);
            errors++;
         end
      end

      // long output hold-off while input keeps coming
      fork
         begin
            quiet_out = 1'b1;
            repeat (60) @(posedge clock);
            quiet_out = 1'b0;
         end
         send_text("a;b;c;d;e;f;g;h;");
      join

      // random part: fragments, raw noise, a stretch without idling
      for (int n = 0; n < 85; n++) begin
         no_idle = (n >= 30 && n < 50);
         if ($urandom_range(9) < 7) send_text(frags[$urandom_range(frags.size() - 1)]);
         else begin
            c = 7'($urandom_range(127));
            send_word(c, $urandom_range(19) == 0);
         end
      end
      no_idle = 1'b0;
      send_word(7'h00, 1);
      req_tvalid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/stt_pkg.sv
src/stt_front.sv
src/stt_fifo.sv
src/stt_back.sv
src/scene_text_tokenizer_top.sv
tb/testbench.sv
